/* src/bmmu_pkg.sv */
// bmmu_pkg: types, register addresses and constants shared by the
// bank mapper channels and the core. no dependencies.
package bmmu_pkg;

    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned PHYS_W      = 21;
    localparam int unsigned PAGE_W      = 13;
    localparam int unsigned SLOT_W      = 3;
    localparam int unsigned MAP_DEPTH   = 16;
    localparam int unsigned MAP_IDX_W   = $clog2(MAP_DEPTH);

    typedef enum logic [1:0] {
        ROUTE_REG  = 2'd0,
        ROUTE_XRAM = 2'd1,
        ROUTE_SAM  = 2'd2
    } t_route;

    // bus register addresses
    localparam logic [ADDR_W-1:0]   MAP_BASE    = 16'hffa0;
    localparam logic [ADDR_W-1:0]   MAP_LAST    = 16'hffaf;
    localparam logic [ADDR_W-1:0]   CTRL0_ADDR  = 16'hff90;
    localparam logic [ADDR_W-1:0]   CTRL1_ADDR  = 16'hff91;

    localparam logic [DATA_W-1:0]   CTRL0_RESET = 8'h80;
    localparam logic [DATA_W-1:0]   PIN_BANK    = 8'h3f;
    localparam logic [DATA_W-1:0]   BANK_INVERT = 8'h38;

    // control zero and control one bit positions
    localparam int unsigned C0_MAP_EN   = 6;
    localparam int unsigned C0_PIN_FE   = 3;
    localparam int unsigned C0_VEC_IO   = 7;
    localparam int unsigned C1_TASK     = 0;

endpackage

/* src/bmmu_if.sv */
// bmmu_if: valid/ready channels for bus access items and translation results.
// depends on bmmu_pkg.
interface bmmu_acc_if
    import bmmu_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               is_read;
    logic [ADDR_W-1:0]  cpu_addr;
    logic [DATA_W-1:0]  write_data;

    modport source (output valid, is_read, cpu_addr, write_data, input ready);
    modport sink   (input valid, is_read, cpu_addr, write_data, output ready);
endinterface

interface bmmu_res_if
    import bmmu_pkg::*;
();
    logic               valid;
    logic               ready;
    t_route             route;
    logic [PHYS_W-1:0]  phys_addr;
    logic [DATA_W-1:0]  read_data;

    modport source (output valid, route, phys_addr, read_data, input ready);
    modport sink   (input valid, route, phys_addr, read_data, output ready);
endinterface

/* src/banked_mmu_address_translator_core.sv */
// banked_mmu_address_translator_core: bank mapper registers and address
// translation for one cpu bus access per item. depends on bmmu_pkg, bmmu_if.
//
// usage:
//   i_acc carries one bus access per item (read flag, cpu address, write
//   data). o_res returns exactly one item per access: route code, 21-bit
//   physical address and register read data.
//   an access to ffa0-ffaf, ff90 or ff91 reads or writes the mapper
//   registers; any other access is translated through the selected task map
//   while control zero bit 6 is set, and passed through unchanged otherwise.
//   the result sits in the output register the cycle after the access is
//   taken. one item per cycle is sustained while the receiver does not
//   stall, set by the single output register; register writes take effect
//   for the very next item.
//   when the receiver stalls the output register holds its item and a new
//   access is taken only in the cycle the held one leaves.
//   reset clears the bank map and control one, sets control zero to 80 and
//   empties the output register.
module banked_mmu_address_translator_core
    import bmmu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    bmmu_acc_if.sink        i_acc,
    bmmu_res_if.source      o_res
);

    logic [DATA_W-1:0]  r_bank_map [MAP_DEPTH];
    logic [DATA_W-1:0]  r_ctrl0;
    logic [DATA_W-1:0]  r_ctrl1;

    logic               r_valid;
    t_route             r_route;
    logic [PHYS_W-1:0]  r_phys;
    logic [DATA_W-1:0]  r_rdata;

    t_route             n_route;
    logic [PHYS_W-1:0]  n_phys;
    logic [DATA_W-1:0]  n_rdata;

    logic               take;
    logic               hit_map;
    logic               hit_c0;
    logic               hit_c1;
    logic               ffxx;
    logic               altvec;
    logic               io_page;
    logic               pin;
    logic [DATA_W-1:0]  bank;
    logic [MAP_IDX_W-1:0] map_idx;
    logic               internal;

    assign i_acc.ready = !r_valid || o_res.ready;
    assign take        = i_acc.valid && i_acc.ready;

    assign hit_map = (i_acc.cpu_addr >= MAP_BASE) && (i_acc.cpu_addr <= MAP_LAST);
    assign hit_c0  = (i_acc.cpu_addr == CTRL0_ADDR);
    assign hit_c1  = (i_acc.cpu_addr == CTRL1_ADDR);

    always_comb begin
        ffxx    = (i_acc.cpu_addr[15:8] == 8'hff);
        altvec  = (i_acc.cpu_addr[15:5] == 11'h7ff) && !r_ctrl0[C0_VEC_IO];
        io_page = ffxx && !altvec;
        pin     = ffxx || ((i_acc.cpu_addr[15:8] == 8'hfe) && r_ctrl0[C0_PIN_FE]);
        map_idx = {r_ctrl1[C1_TASK], i_acc.cpu_addr[ADDR_W-1 -: SLOT_W]};
        bank    = (pin ? PIN_BANK : r_bank_map[map_idx]) ^ BANK_INVERT;
        // of the banks below 8 only bank 7 reaches internal ram, in the top window offsets outside the io page
        internal = (bank[DATA_W-1:3] != '0)
                || ((bank[2:0] == 3'b111) && (i_acc.cpu_addr[12:9] == 4'hf) && !io_page);

        n_route = ROUTE_SAM;
        n_phys  = {{(PHYS_W-ADDR_W){1'b0}}, i_acc.cpu_addr};
        n_rdata = '0;
        if (hit_map) begin
            n_route = ROUTE_REG;
            if (i_acc.is_read) begin
                n_rdata = r_bank_map[i_acc.cpu_addr[MAP_IDX_W-1:0]];
            end
        end else if (hit_c0) begin
            n_route = ROUTE_REG;
            if (i_acc.is_read) begin
                n_rdata = r_ctrl0;
            end
        end else if (hit_c1) begin
            n_route = ROUTE_REG;
            if (i_acc.is_read) begin
                n_rdata = r_ctrl1;
            end
        end else if (r_ctrl0[C0_MAP_EN]) begin
            n_route = internal ? ROUTE_XRAM : ROUTE_SAM;
            n_phys  = {bank, i_acc.cpu_addr[PAGE_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAP_DEPTH; i++) begin
                r_bank_map[i] <= '0;
            end
            r_ctrl0 <= CTRL0_RESET;
            r_ctrl1 <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take && !i_acc.is_read) begin
                if (hit_map) begin
                    r_bank_map[i_acc.cpu_addr[MAP_IDX_W-1:0]] <= i_acc.write_data;
                end else if (hit_c0) begin
                    r_ctrl0 <= i_acc.write_data;
                end else if (hit_c1) begin
                    r_ctrl1 <= i_acc.write_data;
                end
            end
            if (take) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_route <= n_route;
            r_phys  <= n_phys;
            r_rdata <= n_rdata;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.route     = r_route;
    assign o_res.phys_addr = r_phys;
    assign o_res.read_data = r_rdata;

endmodule
